/* rtl/core/binary_to_seven_segment_display_assert.svh */
// assertion macros shared by the checker files
// no dependencies, include by bare file name
`ifndef BINARY_TO_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH
`define BINARY_TO_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define B2SS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b2ss assertion failed");

// next-cycle implication, skipped while reset is high
`define B2SS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b2ss assertion failed");

`endif

/* rtl/core/b2ss_pkg.sv */
// shared types, constants and functions of the binary to seven-segment pipeline
// no dependencies
package b2ss_pkg;

   localparam logic [15:0] MaxShown      = 16'd9999;
   localparam logic [7:0]  PointBit      = 8'h80;
   localparam int          StepsPerStage = 4;
   localparam int          DabbleStages  = 4;

   // work word of the double dabble: bcd digits in [31:16], binary left in [15:0]
   typedef struct packed {
      logic [31:0] acc;
      logic        point;
   } work_type;

   // glyph of one hex digit, segments a..g in bits 0..6
   function automatic logic [7:0] glyph(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'h0:    seg = 8'h3F;
         4'h1:    seg = 8'h06;
         4'h2:    seg = 8'h5B;
         4'h3:    seg = 8'h4F;
         4'h4:    seg = 8'h66;
         4'h5:    seg = 8'h6D;
         4'h6:    seg = 8'h7D;
         4'h7:    seg = 8'h07;
         4'h8:    seg = 8'h7F;
         4'h9:    seg = 8'h6F;
         4'hA:    seg = 8'h5F;
         4'hB:    seg = 8'h7C;
         4'hC:    seg = 8'h58;
         4'hD:    seg = 8'h5E;
         4'hE:    seg = 8'h7B;
         default: seg = 8'h71;
      endcase
      return seg;
   endfunction

   // one shift-and-add-3 step: correct each bcd digit, then shift left
   function automatic logic [31:0] dabble_step(input logic [31:0] acc);
      logic [31:0] adj;
      adj = acc;
      for (int j = 0; j < 4; j++) begin
         if (adj[16 + 4*j +: 4] >= 4'd5) begin
            adj[16 + 4*j +: 4] = adj[16 + 4*j +: 4] + 4'd3;
         end
      end
      return {adj[30:0], 1'b0};
   endfunction

endpackage

/* rtl/core/b2ss_clamp.sv */
// first stage: saturates the signed input to 0..9999 and loads the work word
// depends on b2ss_pkg
module b2ss_clamp (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [15:0]        up_value,
   input  logic               up_point,
   output logic               dn_valid,
   input  logic               dn_ready,
   output b2ss_pkg::work_type dn_work
);

   logic               valid_ff;
   logic               valid_in;
   b2ss_pkg::work_type work_ff;
   b2ss_pkg::work_type work_in;
   logic [15:0]        mag;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // negative values read as large unsigned numbers and saturate too
   always_comb begin
      if (up_value[15] || (up_value > b2ss_pkg::MaxShown)) begin
         mag = b2ss_pkg::MaxShown;
      end else begin
         mag = up_value;
      end
      work_in.acc   = {16'd0, mag};
      work_in.point = up_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         work_ff <= work_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_work  = work_ff;

endmodule

/* rtl/core/b2ss_dabble.sv */
// one pipeline stage of the binary to bcd conversion, four shift-and-add-3 steps
// depends on b2ss_pkg
module b2ss_dabble (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  b2ss_pkg::work_type up_work,
   output logic               dn_valid,
   input  logic               dn_ready,
   output b2ss_pkg::work_type dn_work
);

   logic               valid_ff;
   logic               valid_in;
   b2ss_pkg::work_type work_ff;
   b2ss_pkg::work_type work_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      logic [31:0] acc;
      acc = up_work.acc;
      for (int i = 0; i < b2ss_pkg::StepsPerStage; i++) begin
         acc = b2ss_pkg::dabble_step(acc);
      end
      work_in.acc   = acc;
      work_in.point = up_work.point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         work_ff <= work_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_work  = work_ff;

endmodule

/* rtl/core/b2ss_glyph.sv */
// last stage: maps the four bcd digits to segment bytes, holds the response
// depends on b2ss_pkg
module b2ss_glyph (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  b2ss_pkg::work_type up_work,
   output logic               dn_valid,
   input  logic               dn_ready,
   output logic [31:0]        dn_segments
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] seg_ff;
   logic [31:0] seg_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // thousands in the lowest byte, point on the hundreds digit
   always_comb begin
      seg_in[7:0]   = b2ss_pkg::glyph(up_work.acc[31:28]);
      seg_in[15:8]  = b2ss_pkg::glyph(up_work.acc[27:24])
                      | (up_work.point ? b2ss_pkg::PointBit : 8'h00);
      seg_in[23:16] = b2ss_pkg::glyph(up_work.acc[23:20]);
      seg_in[31:24] = b2ss_pkg::glyph(up_work.acc[19:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         seg_ff <= seg_in;
      end
   end

   assign dn_valid    = valid_ff;
   assign dn_segments = seg_ff;

endmodule

/* rtl/core/binary_to_seven_segment_display.sv */
// Four-digit seven-segment encoder for a signed 16-bit value.
// Request channel (req_): tdata carries value in bits 15:0 and point_on in
// bit 16; a request is taken on a rising edge with req_tvalid and req_tready.
// Response channel (rsp_): tdata carries the four segment bytes, thousands
// digit in bits 7:0, then hundreds, tens and units; bit 7 of each byte is the
// decimal point, lit only on the hundreds digit when point_on was set.
// Values that are negative or above 9999 are shown as 9999; leading zeros show.
// Path: a request taken on an edge passes through six register stages in turn:
// clamp, four conversion stages of four shift-and-add-3 steps each, and the
// glyph output stage, which drives rsp_tvalid. Throughput: one request per
// cycle while rsp_tready is high, set by the six-stage register pipeline, each
// stage taking a new request as soon as the one ahead has room.
// Stall: while rsp_tready is low the held response stays unchanged and the
// pipeline fills; req_tready falls once every stage holds a request, and
// nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline; no clearing pass.
// depends on b2ss_pkg, b2ss_clamp, b2ss_dabble, b2ss_glyph
module binary_to_seven_segment_display (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // value[15:0], point_on[16], zero[23:17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // thousands, hundreds, tens, units segments
);

   logic               stg_valid [0:b2ss_pkg::DabbleStages];
   logic               stg_ready [0:b2ss_pkg::DabbleStages];
   b2ss_pkg::work_type stg_work  [0:b2ss_pkg::DabbleStages];

   b2ss_clamp u_clamp (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_value (req_tdata[15:0]),
      .up_point (req_tdata[16]),
      .dn_valid (stg_valid[0]),
      .dn_ready (stg_ready[0]),
      .dn_work  (stg_work[0])
   );

   for (genvar s = 0; s < b2ss_pkg::DabbleStages; s++) begin : g_dabble
      b2ss_dabble u_dabble (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[s]),
         .up_ready (stg_ready[s]),
         .up_work  (stg_work[s]),
         .dn_valid (stg_valid[s+1]),
         .dn_ready (stg_ready[s+1]),
         .dn_work  (stg_work[s+1])
      );
   end

   b2ss_glyph u_glyph (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (stg_valid[b2ss_pkg::DabbleStages]),
      .up_ready    (stg_ready[b2ss_pkg::DabbleStages]),
      .up_work     (stg_work[b2ss_pkg::DabbleStages]),
      .dn_valid    (rsp_tvalid),
      .dn_ready    (rsp_tready),
      .dn_segments (rsp_tdata)
   );

endmodule

/* rtl/core/b2ss_checker.sv */
// port-level checks on the seven-segment encoder, bound to the top level
// depends on binary_to_seven_segment_display_assert.svh
`include "binary_to_seven_segment_display_assert.svh"

module b2ss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a held response keeps its value
   `B2SS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // only the hundreds digit ever lights its point
   `B2SS_ASSERT_NOW(a_point_place, clock, reset, rsp_tvalid,
      !rsp_tdata[7] && !rsp_tdata[23] && !rsp_tdata[31])

   // a free output means every stage has room
   `B2SS_ASSERT_NOW(a_no_bubble_stall, clock, reset, rsp_tready, req_tready)

endmodule

bind binary_to_seven_segment_display b2ss_checker u_b2ss_checker (.*);
